/* rtl/core/pidaw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID anti-windup package
// Widths, register indices, command codes and the structures shared by the
// configuration block, the datapath and the top level.
// ----------------------------------------------------------------------------
package pidaw_pkg;

   localparam int SPEED_W    = 24;
   localparam int GAIN_W     = 16;
   localparam int INTEG_W    = 40;
   localparam int ERR_W      = 25;
   localparam int DIFF_W     = 26;
   localparam int THR_W      = 23;
   localparam int FRAC_SHIFT = 12;
   localparam int P_PROD_W   = GAIN_W + ERR_W;
   localparam int D_PROD_W   = GAIN_W + DIFF_W;
   localparam int I_PROD_W   = GAIN_W + INTEG_W;
   localparam int ACC_W      = I_PROD_W + 2;
   localparam int SHIFTED_W  = ACC_W - FRAC_SHIFT;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PROP_GAIN   = 3'd0,
      CSR_INTEG_GAIN  = 3'd1,
      CSR_DERIV_GAIN  = 3'd2,
      CSR_UPPER_LIMIT = 3'd3,
      CSR_LOWER_LIMIT = 3'd4,
      CSR_SEP_THRESH  = 3'd5
   } csr_index_type;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0]  prop_gain;
      logic signed [GAIN_W-1:0]  integ_gain;
      logic signed [GAIN_W-1:0]  deriv_gain;
      logic signed [SPEED_W-1:0] upper_limit;
      logic signed [SPEED_W-1:0] lower_limit;
      logic        [THR_W-1:0]   sep_threshold;
   } pid_cfg_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed;
      logic signed [INTEG_W-1:0] integral;
      logic signed [ERR_W-1:0]   prev_err;
   } pid_state_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] new_speed;
      logic                      integral_on;
      logic                      clipped;
   } pid_result_type;

   localparam logic signed [GAIN_W-1:0]  RESET_GAIN  = 16'sd205;
   localparam logic signed [SPEED_W-1:0] RESET_UPPER = 24'sd25600;
   localparam logic signed [SPEED_W-1:0] RESET_LOWER = -24'sd25600;
   localparam logic        [THR_W-1:0]   RESET_THR   = 23'd51200;

   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
   localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0]   ROUND_HALF = ACC_W'(2048);

endpackage

/* rtl/core/pidaw_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID configuration registers
// Holds the gains, speed limits and separation threshold; written through a
// plain write port with no read-back.
// ----------------------------------------------------------------------------
module pidaw_csr import pidaw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output pid_cfg_type           cfg
);

   pid_cfg_type cfg_ff;
   pid_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_PROP_GAIN:   cfg_in.prop_gain     = csr_wdata[GAIN_W-1:0];
            CSR_INTEG_GAIN:  cfg_in.integ_gain    = csr_wdata[GAIN_W-1:0];
            CSR_DERIV_GAIN:  cfg_in.deriv_gain    = csr_wdata[GAIN_W-1:0];
            CSR_UPPER_LIMIT: cfg_in.upper_limit   = csr_wdata[SPEED_W-1:0];
            CSR_LOWER_LIMIT: cfg_in.lower_limit   = csr_wdata[SPEED_W-1:0];
            CSR_SEP_THRESH:  cfg_in.sep_threshold = csr_wdata[THR_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= RESET_GAIN;
         cfg_ff.integ_gain    <= RESET_GAIN;
         cfg_ff.deriv_gain    <= RESET_GAIN;
         cfg_ff.upper_limit   <= RESET_UPPER;
         cfg_ff.lower_limit   <= RESET_LOWER;
         cfg_ff.sep_threshold <= RESET_THR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/pidaw_calc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID step datapath
// Forms the error, decides separation and anti-windup, updates the integral
// and sums the three products into a rounded, saturated speed.
// ----------------------------------------------------------------------------
module pidaw_calc import pidaw_pkg::*; (
   input  logic                      cmd,
   input  logic signed [SPEED_W-1:0] value,
   input  pid_cfg_type               cfg,
   input  pid_state_type             state,
   output pid_state_type             state_next,
   output pid_result_type            result
);

   logic signed [ERR_W-1:0]     err;
   logic        [ERR_W-1:0]     err_mag;
   logic                        integ_on;
   logic                        integ_add;
   logic signed [INTEG_W:0]     integ_sum;
   logic                        integ_ovf;
   logic signed [INTEG_W-1:0]   integ_new;
   logic signed [DIFF_W-1:0]    err_diff;
   logic signed [P_PROD_W-1:0]  p_prod;
   logic signed [D_PROD_W-1:0]  d_prod;
   logic signed [I_PROD_W-1:0]  i_prod;
   logic signed [ACC_W-1:0]     acc;
   logic signed [SHIFTED_W-1:0] acc_shifted;
   logic                        out_hi;
   logic                        out_lo;
   logic signed [SPEED_W-1:0]   speed_out;

   assign err     = $signed({value[SPEED_W-1], value})
                  - $signed({state.speed[SPEED_W-1], state.speed});
   assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
   assign integ_on = err_mag <= {{(ERR_W-THR_W){1'b0}}, cfg.sep_threshold};

   // The upper limit is tested first, so crossed limits favour it.
   always_comb begin
      if (state.speed > cfg.upper_limit) begin
         integ_add = err[ERR_W-1];
      end else if (state.speed < cfg.lower_limit) begin
         integ_add = !err[ERR_W-1] && (err != '0);
      end else begin
         integ_add = 1'b1;
      end
   end

   assign integ_sum = $signed({state.integral[INTEG_W-1], state.integral})
                    + $signed({{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err});
   assign integ_ovf = integ_sum[INTEG_W] != integ_sum[INTEG_W-1];

   always_comb begin
      if (integ_on && integ_add) begin
         if (integ_ovf) begin
            integ_new = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
         end else begin
            integ_new = integ_sum[INTEG_W-1:0];
         end
      end else begin
         integ_new = state.integral;
      end
   end

   assign err_diff = $signed({err[ERR_W-1], err})
                   - $signed({state.prev_err[ERR_W-1], state.prev_err});

   assign p_prod = cfg.prop_gain * err;
   assign d_prod = cfg.deriv_gain * err_diff;
   assign i_prod = cfg.integ_gain * integ_new;

   // Products are summed at 20 fraction bits and rounded half up to Q.8.
   assign acc = ACC_W'(p_prod) + ACC_W'(d_prod)
              + (integ_on ? ACC_W'(i_prod) : ACC_W'(0)) + ROUND_HALF;
   assign acc_shifted = SHIFTED_W'(acc >>> FRAC_SHIFT);
   assign out_hi = acc_shifted > SHIFTED_W'(SPEED_MAX);
   assign out_lo = acc_shifted < SHIFTED_W'(SPEED_MIN);

   always_comb begin
      if (out_hi) begin
         speed_out = SPEED_MAX;
      end else if (out_lo) begin
         speed_out = SPEED_MIN;
      end else begin
         speed_out = acc_shifted[SPEED_W-1:0];
      end
   end

   always_comb begin
      if (cmd_type'(cmd) == CMD_LOAD) begin
         state_next.speed    = value;
         state_next.integral = state.integral;
         state_next.prev_err = state.prev_err;
         result.new_speed    = value;
         result.integral_on  = 1'b0;
         result.clipped      = 1'b0;
      end else begin
         state_next.speed    = speed_out;
         state_next.integral = integ_new;
         state_next.prev_err = err;
         result.new_speed    = speed_out;
         result.integral_on  = integ_on;
         result.clipped      = (integ_on && integ_add && integ_ovf) || out_hi || out_lo;
      end
   end

endmodule

/* rtl/core/pid_antiwindup_integral_separation_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller with anti-windup and integral separation
// Positional PID on Q16.8 speeds with Q4.12 gains; the output becomes the
// new speed. A load command sets the speed directly.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transaction contents
//   req_      in         tdata: value (24b); tuser: cmd (0 tick, 1 load)
//   rsp_      out        tdata: new_speed (24b); tuser: integral_on, clipped
//   csr_      in         write enable, 3-bit register index, 24-bit data
//
// Each transaction is captured in the input register at its accepting edge and
// is computed in a single combinational pass into the result register once that
// register is free, where its result is offered; one transaction is taken
// every cycle while rsp_ is not stalled. The controller state (speed, integral,
// previous error) updates as a transaction moves into the result register.
// Reset is synchronous, clears state and valid flags and restores the CSRs.
// A stalled result holds the input register; neither side loses data.
// ----------------------------------------------------------------------------
module pid_antiwindup_integral_separation_unit import pidaw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SPEED_W-1:0]    req_tdata,   // [23:0] value
   input  logic                  req_tuser,   // [0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SPEED_W-1:0]    rsp_tdata,   // [23:0] new_speed
   output logic [1:0]            rsp_tuser,   // [0] integral_on, [1] clipped
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   pid_cfg_type           cfg;
   pid_state_type         state_ff;
   pid_state_type         state_in;
   pid_result_type        result_calc;
   pid_result_type        result_ff;
   logic                  in_valid_ff;
   logic                  in_cmd_ff;
   logic [SPEED_W-1:0]    in_value_ff;
   logic                  out_valid_ff;
   logic                  out_free;
   logic                  advance;

   pidaw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidaw_calc u_calc (
      .cmd        (in_cmd_ff),
      .value      (in_value_ff),
      .cfg        (cfg),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_calc)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff   <= req_tuser;
         in_value_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_calc;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = result_ff.new_speed;
   assign rsp_tuser  = {result_ff.clipped, result_ff.integral_on};

endmodule
